// ===== rtl/rsw_pkg.sv =====
// Shared types and constants for the RMS-scaled weight update block.
// No dependencies; imported by rsw_root, rms_scaled_weight_update and the testbench.
package rsw_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned IdxW   = 12;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned MulW   = 33;
  localparam int unsigned ProdW  = 2 * MulW;
  localparam int unsigned QuoW   = 49;

  localparam logic [CfgIdxW-1:0] CFG_LEARNING_RATE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_REG_LAMBDA    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DECAY         = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_STEP_REG      = 2'd3;

  localparam logic [CfgW-1:0] RstLearningRate = 16'd655;
  localparam logic [CfgW-1:0] RstRegLambda    = 16'd0;
  localparam logic [CfgW-1:0] RstDecay        = 16'd58982;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LW, S_GR, S_SQ, S_SQC, S_C1, S_C2, S_CS, S_KICK,
    S_ROOT, S_T, S_TS, S_U1, S_U2, S_U3, S_OUT
  } main_state_e;

  typedef enum logic [1:0] {
    R_IDLE, R_DIV, R_SQRT, R_DONE
  } root_state_e;

  typedef struct packed {
    logic done;
    logic zero;
  } root_stat_t;

endpackage

// ===== rtl/rsw_root.sv =====
// Inverse square root unit: r = isqrt(floor(2^48 / c)), one bit per cycle.
// Restoring division then digit-by-digit root; depends on rsw_pkg.
module rsw_root (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rsw_pkg::DataW-1:0] c_i,
  output logic [rsw_pkg::DataW-1:0] r_o,
  output rsw_pkg::root_stat_t       stat_o
);
  import rsw_pkg::*;

  root_state_e state_q, state_d;
  logic [5:0]        cnt_q, cnt_d;
  logic [DataW-1:0]  div_q, div_d;
  logic [DataW-1:0]  rem_q, rem_d;
  logic [QuoW-1:0]   n_q, n_d;
  logic [QuoW-1:0]   res_q, res_d;
  logic [QuoW-1:0]   bit_q, bit_d;
  logic              zero_q, zero_d;
  logic [DataW:0]    rem_sh;
  logic [QuoW-1:0]   trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      zero_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      zero_q  <= zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    div_q <= div_d;
    rem_q <= rem_d;
    n_q   <= n_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    div_d   = div_q;
    rem_d   = rem_q;
    n_d     = n_q;
    res_d   = res_q;
    bit_d   = bit_q;
    zero_d  = zero_q;
    // only the top dividend bit (2^48) is set
    rem_sh  = {rem_q, (cnt_q == 6'(QuoW - 1))};
    trial   = res_q + bit_q;
    case (state_q)
      R_IDLE: begin
        if (start_i) begin
          div_d  = c_i;
          rem_d  = '0;
          n_d    = '0;
          cnt_d  = 6'(QuoW - 1);
          zero_d = (c_i == '0);
          state_d = (c_i == '0) ? R_DONE : R_DIV;
        end
      end
      R_DIV: begin
        // n_q collects the quotient
        if (rem_sh >= {1'b0, div_q}) begin
          rem_d = DataW'(rem_sh - {1'b0, div_q});
          n_d   = {n_q[QuoW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[DataW-1:0];
          n_d   = {n_q[QuoW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          res_d   = '0;
          bit_d   = {1'b1, {(QuoW-1){1'b0}}};
          state_d = R_SQRT;
        end
      end
      R_SQRT: begin
        if (n_q >= trial) begin
          n_d   = n_q - trial;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) state_d = R_DONE;
      end
      R_DONE: begin
        state_d = R_IDLE;
      end
      default: state_d = R_IDLE;
    endcase
  end

  assign r_o         = zero_q ? '1 : res_q[DataW-1:0];
  assign stat_o.done = (state_q == R_DONE);
  assign stat_o.zero = zero_q;

endmodule

// ===== rtl/rms_scaled_weight_update.sv =====
// Top level of the RMS-scaled weight update block (RMSprop-style step).
// Depends on rsw_pkg and rsw_root.
//
// Usage:
//  - Command channel: drive param_index_i, gradient_i, weight_in_i and raise
//    start_i; the transfer happens at a rising edge with start_i high and
//    busy_o low. The block holds busy_o high until the result is out.
//  - Result: done_o pulses for one cycle with weight_out_o and saturated_o.
//    The receiver cannot stall; take the result in that cycle.
//  - Configuration: cfg_we_i with cfg_idx_i (0 learning rate, 1 lambda,
//    2 decay, 3 step mode) and cfg_wdata_i, taken at once. Write only idle.
//  - Sequence: 14 sequencer steps around seven products on the one shared
//    33x33 multiplier, plus rsw_root (restoring division 2^48 / cache, then
//    square root, then hand-off). A zero cache skips the root.
//    busy_o drops with done_o, so the next transfer can land on the edge
//    that ends the done_o cycle.
//  - Reset: registers take their defaults, and the cache memory is swept
//    to zero one entry per cycle, all min(NUM_PARAMS, 4096) entries, with
//    busy_o high. Configuration writes are taken during the sweep.
//  - An index at or beyond NUM_PARAMS sees a zero cache and stores nothing.
module rms_scaled_weight_update #(
  parameter int unsigned NUM_PARAMS = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [rsw_pkg::IdxW-1:0]    param_index_i,
  input  logic signed [rsw_pkg::DataW-1:0] gradient_i,
  input  logic signed [rsw_pkg::DataW-1:0] weight_in_i,
  output logic                        done_o,
  output logic signed [rsw_pkg::DataW-1:0] weight_out_o,
  output logic                        saturated_o,
  input  logic                        cfg_we_i,
  input  logic [rsw_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rsw_pkg::CfgW-1:0]    cfg_wdata_i
);
  import rsw_pkg::*;

  localparam int unsigned MaxDepth = 1 << IdxW;
  localparam int unsigned Depth = (NUM_PARAMS < MaxDepth) ? NUM_PARAMS : MaxDepth;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  // configuration registers
  logic [CfgW-1:0] lr_q, lambda_q, decay_q;
  logic            step_reg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q       <= RstLearningRate;
      lambda_q   <= RstRegLambda;
      decay_q    <= RstDecay;
      step_reg_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LEARNING_RATE: lr_q       <= cfg_wdata_i;
        CFG_REG_LAMBDA:    lambda_q   <= cfg_wdata_i;
        CFG_DECAY:         decay_q    <= cfg_wdata_i;
        CFG_STEP_REG:      step_reg_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  main_state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          done_q, done_d;
  logic          sat_q, sat_d;

  // item payload and intermediates
  logic [IdxW-1:0]         idx_q;
  logic signed [DataW-1:0] g_q, w_q, gr_q, gr_d;
  logic [DataW-1:0]        sq_q, sq_d, c_q, c_d, old_q;
  logic signed [ProdW-1:0] p_q, acc_q, acc_d;
  logic signed [47:0]      t_q, t_d;
  logic signed [48:0]      u_q, u_d;
  logic signed [DataW-1:0] wout_q, wout_d;

  logic signed [MulW-1:0]  opa, opb;
  logic [DataW-1:0]        mem [Depth];
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [DataW-1:0]        mem_wdata;
  logic                    in_store;
  logic                    accept;

  logic signed [33:0]      gr_sum;
  logic [49:0]             c_sum;
  logic signed [ProdW-1:0] u_sum;
  logic signed [49:0]      wn_sum;
  logic signed [DataW-1:0] s_sel;
  logic                    root_start;
  logic [DataW-1:0]        r;
  root_stat_t              root_stat;

  assign accept   = start_i && !busy_o;
  assign in_store = 32'(idx_q) < NUM_PARAMS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  // shared multiplier, product registered
  always_ff @(posedge clk_i) begin
    p_q    <= opa * opb;
    acc_q  <= acc_d;
    gr_q   <= gr_d;
    sq_q   <= sq_d;
    c_q    <= c_d;
    t_q    <= t_d;
    u_q    <= u_d;
    wout_q <= wout_d;
    sat_q  <= sat_d;
    if (accept) begin
      idx_q <= param_index_i;
      g_q   <= gradient_i;
      w_q   <= weight_in_i;
    end
  end

  // cache memory: one write port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (accept) old_q <= mem[param_index_i[AW-1:0]];
  end

  rsw_root u_root (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(root_start),
    .c_i    (c_q),
    .r_o    (r),
    .stat_o (root_stat)
  );

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    done_d     = 1'b0;
    sat_d      = sat_q;
    acc_d      = acc_q;
    gr_d       = gr_q;
    sq_d       = sq_q;
    c_d        = c_q;
    t_d        = t_q;
    u_d        = u_q;
    wout_d     = wout_q;
    opa        = '0;
    opb        = '0;
    mem_we     = 1'b0;
    mem_waddr  = idx_q[AW-1:0];
    mem_wdata  = c_q;
    root_start = 1'b0;
    s_sel      = step_reg_q ? gr_q : g_q;
    gr_sum     = {{2{g_q[DataW-1]}}, g_q} + p_q[49:16];
    c_sum      = {1'b0, acc_q[48:0]} + {1'b0, p_q[48:0]};
    u_sum      = (acc_q <<< 24) + p_q;
    wn_sum     = {{18{w_q[DataW-1]}}, w_q} - {u_q[48], u_q};
    case (state_q)
      S_CLEAR: begin
        // sweep the cache to zero after reset
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(Depth - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          sat_d   = 1'b0;
          state_d = S_LW;
        end
      end
      S_LW: begin
        opa     = MulW'(w_q);
        opb     = {17'b0, lambda_q};
        state_d = S_GR;
      end
      S_GR: begin
        if (gr_sum > 34'sh7FFFFFFF) begin
          gr_d = 32'sh7FFFFFFF;
          sat_d = 1'b1;
        end else if (gr_sum < -34'sh80000000) begin
          gr_d = 32'sh80000000;
          sat_d = 1'b1;
        end else begin
          gr_d = gr_sum[DataW-1:0];
        end
        state_d = S_SQ;
      end
      S_SQ: begin
        opa     = MulW'(gr_q);
        opb     = MulW'(gr_q);
        state_d = S_SQC;
      end
      S_SQC: begin
        if (|p_q[ProdW-1:48]) begin
          sq_d  = '1;
          sat_d = 1'b1;
        end else begin
          sq_d = p_q[47:16];
        end
        state_d = S_C1;
      end
      S_C1: begin
        opa     = {16'b0, 17'h10000 - {1'b0, decay_q}};
        opb     = {1'b0, sq_q};
        state_d = S_C2;
      end
      S_C2: begin
        acc_d   = p_q;
        opa     = {17'b0, decay_q};
        opb     = in_store ? {1'b0, old_q} : '0;
        state_d = S_CS;
      end
      S_CS: begin
        c_d     = c_sum[47:16];
        state_d = S_KICK;
      end
      S_KICK: begin
        // kick the root unit and store the new average
        root_start = 1'b1;
        mem_we     = in_store;
        state_d    = S_ROOT;
      end
      S_ROOT: begin
        // wait on the root unit
        if (root_stat.done) begin
          if (root_stat.zero) sat_d = 1'b1;
          state_d = S_T;
        end
      end
      S_T: begin
        opa     = MulW'(s_sel);
        opb     = {1'b0, r};
        state_d = S_TS;
      end
      S_TS: begin
        t_d     = p_q[63:16];
        state_d = S_U1;
      end
      S_U1: begin
        opa     = MulW'($signed(t_q[47:24]));
        opb     = {17'b0, lr_q};
        state_d = S_U2;
      end
      S_U2: begin
        acc_d   = p_q;
        opa     = {9'b0, t_q[23:0]};
        opb     = {17'b0, lr_q};
        state_d = S_U3;
      end
      S_U3: begin
        u_d     = u_sum[64:16];
        state_d = S_OUT;
      end
      S_OUT: begin
        if (wn_sum > 50'sh7FFFFFFF) begin
          wout_d = 32'sh7FFFFFFF;
          sat_d  = 1'b1;
        end else if (wn_sum < -50'sh80000000) begin
          wout_d = 32'sh80000000;
          sat_d  = 1'b1;
        end else begin
          wout_d = wn_sum[DataW-1:0];
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign weight_out_o = wout_q;
  assign saturated_o  = sat_q;

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for rms_scaled_weight_update: directed and random
// optimizer steps checked against an in-bench fixed-point step predictor.
// Depends on rsw_pkg and the rms_scaled_weight_update RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rsw_pkg::*;

  localparam int unsigned NParams = 4096;
  localparam longint CycleLimit = 1000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [IdxW-1:0] param_index_i = '0;
  logic signed [DataW-1:0] gradient_i = '0;
  logic signed [DataW-1:0] weight_in_i = '0;
  logic done_o;
  logic signed [DataW-1:0] weight_out_o;
  logic saturated_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_wdata_i = '0;

  typedef struct packed {
    logic signed [DataW-1:0] weight;
    logic                    sat;
  } step_result_t;

  // Predictor state: shadow cache and shadow registers.
  logic [31:0] avg_shadow [NParams];
  logic [15:0] rate_q, lambda_q, decay_q;
  logic        use_reg_q;

  step_result_t pending_steps[$];
  int unsigned fail_count = 0;
  int unsigned step_count = 0;
  longint cycle_count = 0;

  rms_scaled_weight_update #(.NUM_PARAMS(NParams)) dut (.*);

  always #5 clk_i = ~clk_i;

  // Bound the run in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // floor(v / 2^16)
  function automatic longint floor_div16(longint v);
    return v >>> 16;
  endfunction

  function automatic longint clamp_s32(longint v, ref bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Predict one step and advance the shadow cache.
  function automatic step_result_t predict_step(logic [IdxW-1:0] idx,
                                                logic signed [31:0] g_in,
                                                logic signed [31:0] w_in);
    bit sat;
    longint g, w, gr, s, t, u;
    longint unsigned sq, oldc, c, r;
    step_result_t res;
    sat = 1'b0;
    g = g_in;
    w = w_in;
    gr = clamp_s32(g + floor_div16(longint'(lambda_q) * w), sat);
    sq = longint'(gr * gr) >> 16;
    if (sq > 64'hFFFF_FFFF) begin
      sq = 64'hFFFF_FFFF;
      sat = 1'b1;
    end
    oldc = (idx < NParams) ? avg_shadow[idx] : 0;
    c = ((65536 - longint'(decay_q)) * sq + longint'(decay_q) * oldc) >> 16;
    if (c > 64'hFFFF_FFFF) begin
      c = 64'hFFFF_FFFF;
      sat = 1'b1;
    end
    if (idx < NParams) avg_shadow[idx] = c[31:0];
    if (c == 0) begin
      r = 64'hFFFF_FFFF;
      sat = 1'b1;
    end else begin
      r = int_sqrt((64'd1 << 48) / c);
    end
    s = use_reg_q ? gr : g;
    t = floor_div16(s * longint'(r));
    u = floor_div16(t * longint'(rate_q));
    res.weight = 32'(clamp_s32(w - u, sat));
    res.sat = sat;
    return res;
  endfunction

  // Compare each result strobe with the oldest expectation.
  always @(posedge clk_i) begin
    step_result_t exp_r;
    if (rst_ni && done_o) begin
      if (pending_steps.size() == 0) begin
        $error("unexpected result weight_out=%0h", weight_out_o);
        fail_count++;
      end else begin
        exp_r = pending_steps.pop_front();
        if (weight_out_o !== exp_r.weight) begin
          $error("weight_out expected %0h actual %0h", exp_r.weight, weight_out_o);
          fail_count++;
        end
        if (saturated_o !== exp_r.sat) begin
          $error("saturated expected %0b actual %0b", exp_r.sat, saturated_o);
          fail_count++;
        end
      end
    end
  end

  // Write one register and mirror it in the shadow copy; the caller drops
  // the write enable after the last write.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_LEARNING_RATE: rate_q = val;
      CFG_REG_LAMBDA:    lambda_q = val;
      CFG_DECAY:         decay_q = val;
      CFG_STEP_REG:      use_reg_q = val[0];
      default: ;
    endcase
  endtask

  // Drop start, hold until every expected result has come, then settle.
  task automatic drain();
    start_i <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_all(logic [15:0] rate, logic [15:0] lam, logic [15:0] dec,
                         logic mode);
    drain();
    write_reg(CFG_LEARNING_RATE, rate);
    write_reg(CFG_REG_LAMBDA, lam);
    write_reg(CFG_DECAY, dec);
    write_reg(CFG_STEP_REG, {15'd0, mode});
    cfg_we_i <= 1'b0;
  endtask

  // Send one step; the transfer happens at the edge where busy_o is low.
  // start_i stays high until the next send or until the caller drops it.
  task automatic send_step(logic [IdxW-1:0] idx, logic [31:0] g, logic [31:0] w);
    start_i <= 1'b1;
    param_index_i <= idx;
    gradient_i <= g;
    weight_in_i <= w;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_steps.push_back(predict_step(idx, g, w));
    step_count++;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 65536 * 4) - 65536 * 2;
      1: return $urandom;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      3: return $urandom_range(0, 3) - 1;
      default: return $urandom_range(0, 65536 * 64) - 65536 * 32;
    endcase
  endfunction

  task automatic test_extremes();
    send_step(12'd0, 32'h0, 32'h0);             // zero cache
    send_step(12'd0, 32'h0001_0000, 32'h0001_0000);
    send_step(12'd4095, 32'h7FFF_FFFF, 32'h8000_0000);
    send_step(12'd4095, 32'h8000_0000, 32'h7FFF_FFFF);
    send_step(12'd1, 32'hFFFF_FFFF, 32'h0000_0001);
    send_step(12'd2, 32'h0000_0001, 32'hFFFF_FFFF);
    send_step(12'hAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_step(12'h555, 32'hAAAA_AAAA, 32'h5555_5555);
  endtask

  task automatic test_register_corners();
    set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_step(12'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF);   // lambda overflow
    send_step(12'd3, 32'h8000_0000, 32'h8000_0000);
    set_all(16'd0, 16'd0, 16'd0, 1'b0);               // zero rate and decay
    send_step(12'd4, 32'h0003_0000, 32'h1234_5678);
    send_step(12'd4, 32'h0000_0000, 32'h0000_0000);
    set_all(16'd1, 16'h8000, 16'd1, 1'b0);
    send_step(12'd5, 32'h0002_0000, 32'hFFFE_0000);
    send_step(12'd5, 32'hFFFF_0000, 32'h0002_0000);
    set_all(16'hFFFF, 16'h0100, 16'd58982, 1'b1);
    send_step(12'd6, 32'h0000_0010, 32'h7FFF_0000);
    send_step(12'd6, 32'h0000_0000, 32'h8001_0000);
  endtask

  // Bursts of random steps on a small hot set of indexes so averages build up.
  task automatic test_random(int unsigned count);
    int unsigned sent, burst, next_cfg;
    logic [IdxW-1:0] idx;
    sent = 0;
    next_cfg = 250;
    while (sent < count) begin
      if (sent >= next_cfg) begin
        set_all(16'($urandom_range(1, 65535)), $urandom_range(0, 3) == 0 ? 16'd0 :
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                1'($urandom_range(0, 1)));
        next_cfg += 250;
      end
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        idx = $urandom_range(0, 3) == 0 ? IdxW'($urandom) : IdxW'($urandom_range(0, 15));
        send_step(idx, rand_value(), rand_value());
        sent++;
      end
      if ($urandom_range(0, 9) == 0) drain();
      else begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NParams; i++) avg_shadow[i] = '0;
    rate_q = RstLearningRate;
    lambda_q = RstRegLambda;
    decay_q = RstDecay;
    use_reg_q = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_register_corners();
    test_random(1230);
    drain();
    repeat (100) @(posedge clk_i);
    $display("Covered %0d steps: field extremes, zero cache, saturation, register corners,",
             step_count);
    $display("and random bursts over several register settings.");
    if (fail_count == 0 && pending_steps.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/rsw_pkg.sv
rtl/rsw_root.sv
rtl/rms_scaled_weight_update.sv
sim/tb.sv
